@@ design/mcl_pkg.sv @@
// ----------------------------------------------------------------------------
// mcl_pkg: shared definitions for the month calendar layout block
// Types, constants and small tables used by the sequencer, the shared
// divide unit and the day emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package mcl_pkg;

    // Field widths
    localparam int YEAR_W    = 14;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int WEEKDAY_W = 3;

    // Shared divide unit: dividend width, remainder width
    localparam int DIV_W = 15;
    localparam int REM_W = 7;

    // Scaled reciprocals: the quotient is (x * RECIP) >> SHIFT. Both are exact
    // for every dividend below 43690, which covers the whole dividend width.
    localparam int                 RECIP_W             = 15;
    localparam logic [RECIP_W-1:0] RECIP_CENTURY       = RECIP_W'(5243);
    localparam int                 RECIP_SHIFT_CENTURY = 19;
    localparam logic [RECIP_W-1:0] RECIP_WEEK          = RECIP_W'(18725);
    localparam int                 RECIP_SHIFT_WEEK    = 17;

    // Quotient of a year by one hundred never exceeds eight bits
    localparam int CENT_W = 8;
    // Zeller month term fits in six bits
    localparam int MTERM_W = 6;

    localparam logic [DIV_W-1:0]   YEAR_OFFSET     = DIV_W'(400);
    localparam logic [REM_W-1:0]   DIVISOR_CENTURY = REM_W'(100);
    localparam logic [REM_W-1:0]   DIVISOR_WEEK    = REM_W'(7);

    localparam logic [MONTH_W-1:0] MONTH_JAN   = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB   = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_MAR   = MONTH_W'(3);
    localparam logic [MONTH_W-1:0] MONTH_APR   = MONTH_W'(4);
    localparam logic [MONTH_W-1:0] MONTH_MAY   = MONTH_W'(5);
    localparam logic [MONTH_W-1:0] MONTH_JUN   = MONTH_W'(6);
    localparam logic [MONTH_W-1:0] MONTH_JUL   = MONTH_W'(7);
    localparam logic [MONTH_W-1:0] MONTH_AUG   = MONTH_W'(8);
    localparam logic [MONTH_W-1:0] MONTH_SEP   = MONTH_W'(9);
    localparam logic [MONTH_W-1:0] MONTH_OCT   = MONTH_W'(10);
    localparam logic [MONTH_W-1:0] MONTH_NOV   = MONTH_W'(11);
    localparam logic [MONTH_W-1:0] MONTH_DEC   = MONTH_W'(12);
    localparam logic [MONTH_W-1:0] MONTH_SHIFT = MONTH_W'(12);

    localparam logic [WEEKDAY_W-1:0] WD_SUNDAY   = WEEKDAY_W'(0);
    localparam logic [WEEKDAY_W-1:0] WD_SATURDAY = WEEKDAY_W'(6);

    localparam logic [DAY_W-1:0] DAYS_LONG  = DAY_W'(31);
    localparam logic [DAY_W-1:0] DAYS_SHORT = DAY_W'(30);
    localparam logic [DAY_W-1:0] DAYS_LEAP  = DAY_W'(29);
    localparam logic [DAY_W-1:0] DAYS_FEB   = DAY_W'(28);
    localparam logic [DAY_W-1:0] DAY_FIRST  = DAY_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_YEAR,
        ST_SUM,
        ST_DIV_SUM,
        ST_EMIT
    } mcl_state_t;

    typedef enum logic {
        DIV_BY_CENTURY,
        DIV_BY_WEEK
    } div_sel_t;

    typedef struct packed {
        logic             start;
        div_sel_t         sel;
        logic [DIV_W-1:0] dividend;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [REM_W-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic                 start;
        logic [DAY_W-1:0]     days;
        logic [WEEKDAY_W-1:0] first_wd;
        logic                 month_match;
        logic [DAY_W-1:0]     today_day;
    } emit_cmd_t;

    // Month term of Zeller's congruence, floor(13 * (m + 1) / 5)
    function automatic logic [MTERM_W-1:0] zeller_month_term(input logic [MONTH_W-1:0] m);
        logic [MTERM_W-1:0] t;
        case (m)
            4'd0:    t = 6'd2;
            4'd1:    t = 6'd5;
            4'd2:    t = 6'd7;
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            4'd12:   t = 6'd33;
            4'd13:   t = 6'd36;
            4'd14:   t = 6'd39;
            default: t = 6'd41;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

@@ design/month_calendar_layout_top.sv @@
// ----------------------------------------------------------------------------
// month_calendar_layout_top: one month of calendar days per request
// Sequencer, shared constant divider and day emitter for a month view.
// ----------------------------------------------------------------------------
// A request carries a year, the month to show and today's month and day. The
// block answers with one transaction per day of the shown month, from the
// 1st, each with its weekday (0 is Sunday), a weekend flag, a today flag and
// a marker on the last day. The weekday of the 1st follows Zeller's
// congruence, with January and February treated as months 13 and 14 of the
// previous year, and the year offset by 400 so that early years stay
// positive. A single constant divider, which multiplies by a scaled
// reciprocal and then subtracts for the remainder, is used twice: once to
// split the offset year by one hundred, which also yields the leap year
// test, and once to reduce the congruence sum modulo seven. After the
// second division the days follow, one per cycle (28 to 31 of them) if the
// consumer keeps up; s_ready is high only between requests. The result
// channel ends in an output register, so the final day may still wait there
// while the next request is accepted. There is no configuration and no state
// kept from one request to the next.
// ----------------------------------------------------------------------------
`default_nettype none

module month_calendar_layout_top
    import mcl_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [YEAR_W-1:0]     s_year,
    input  wire logic [MONTH_W-1:0]    s_shown_month,
    input  wire logic [MONTH_W-1:0]    s_today_month,
    input  wire logic [DAY_W-1:0]      s_today_day,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [DAY_W-1:0]           m_day_of_month,
    output logic [WEEKDAY_W-1:0]       m_weekday,
    output logic                       m_is_weekend,
    output logic                       m_is_today,
    output logic                       m_last_day
);

    mcl_state_t state_reg, state_next;

    // Request held for the duration of the transaction
    logic [YEAR_W-1:0]  year_reg, year_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic               match_reg, match_next;
    logic [DAY_W-1:0]   tday_reg, tday_next;
    logic [DAY_W-1:0]   days_reg, days_next;

    div_req_t  div_req;
    div_rsp_t  div_rsp;
    emit_cmd_t emit_cmd;
    logic      emit_done;
    logic      accept;

    // Congruence terms, formed while the divider is idle after the first pass
    logic [DIV_W-1:0]     year_off;
    logic                 early_month;
    logic [DIV_W-1:0]     zy;
    logic [CENT_W-1:0]    cent_q0;
    logic [REM_W-1:0]     cent_r0;
    logic [CENT_W-1:0]    cent_q;
    logic [MONTH_W-1:0]   zm;
    logic [DIV_W-1:0]     zsum;
    logic                 leap;
    logic [DAY_W-1:0]     month_days;
    logic [WEEKDAY_W-1:0] h_mod;
    logic [WEEKDAY_W-1:0] first_wd;

    assign accept = s_valid && s_ready;

    assign year_off    = {1'b0, year_reg} + YEAR_OFFSET;
    assign early_month = (month_reg == MONTH_JAN) || (month_reg == MONTH_FEB);
    assign zy          = year_off - DIV_W'(early_month);
    assign cent_q0     = div_rsp.quotient[CENT_W-1:0];
    assign cent_r0     = div_rsp.remainder;
    // Stepping back one year crosses a century boundary only when the offset
    // year is an exact multiple of one hundred.
    assign cent_q      = (early_month && (cent_r0 == '0)) ? cent_q0 - CENT_W'(1) : cent_q0;
    assign zm          = early_month ? month_reg + MONTH_SHIFT : month_reg;

    // The year divided by four and by four hundred are shifts of zy and of
    // its century count.
    assign zsum = DIV_W'(1)
                + DIV_W'(zeller_month_term(zm))
                + zy
                + {2'b00, zy[DIV_W-1:2]}
                - DIV_W'(cent_q)
                + DIV_W'(cent_q[CENT_W-1:2]);

    // The offset of 400 leaves the remainders by 4, 100 and 400 unchanged.
    assign leap = (year_reg[1:0] == 2'b00)
               && ((cent_r0 != '0) || (cent_q0[1:0] == 2'b00));

    always_comb begin
        case (month_reg)
            MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
            MONTH_AUG, MONTH_OCT, MONTH_DEC: begin
                month_days = DAYS_LONG;
            end
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: begin
                month_days = DAYS_SHORT;
            end
            MONTH_FEB: begin
                month_days = leap ? DAYS_LEAP : DAYS_FEB;
            end
            default: begin
                month_days = DAYS_SHORT;
            end
        endcase
    end

    // Zeller counts Saturday as zero; shift so that Sunday is zero.
    assign h_mod    = div_rsp.remainder[WEEKDAY_W-1:0];
    assign first_wd = (h_mod == '0) ? WD_SATURDAY : h_mod - WEEKDAY_W'(1);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_DIV_YEAR;
            end
            ST_DIV_YEAR: begin
                if (div_rsp.done) state_next = ST_SUM;
            end
            ST_SUM: begin
                state_next = ST_DIV_SUM;
            end
            ST_DIV_SUM: begin
                if (div_rsp.done) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (emit_done) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        s_ready              = 1'b0;
        div_req.start        = 1'b0;
        div_req.sel          = DIV_BY_CENTURY;
        div_req.dividend     = {1'b0, s_year} + YEAR_OFFSET;
        emit_cmd.start       = 1'b0;
        emit_cmd.days        = days_reg;
        emit_cmd.first_wd    = first_wd;
        emit_cmd.month_match = match_reg;
        emit_cmd.today_day   = tday_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                div_req.start = s_valid;
            end
            ST_SUM: begin
                div_req.start    = 1'b1;
                div_req.sel      = DIV_BY_WEEK;
                div_req.dividend = zsum;
            end
            ST_DIV_SUM: begin
                emit_cmd.start = div_rsp.done;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Request and month length registers
    always_comb begin
        year_next  = year_reg;
        month_next = month_reg;
        match_next = match_reg;
        tday_next  = tday_reg;
        days_next  = days_reg;
        if (accept) begin
            year_next  = s_year;
            month_next = s_shown_month;
            match_next = (s_shown_month == s_today_month);
            tday_next  = s_today_day;
        end
        if (state_reg == ST_SUM) begin
            days_next = month_days;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        year_reg  <= year_next;
        month_reg <= month_next;
        match_reg <= match_next;
        tday_reg  <= tday_next;
        days_reg  <= days_next;
    end

    mcl_div_unit u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    mcl_day_emitter u_emit (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (emit_cmd),
        .done           (emit_done),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_day_of_month (m_day_of_month),
        .m_weekday      (m_weekday),
        .m_is_weekend   (m_is_weekend),
        .m_is_today     (m_is_today),
        .m_last_day     (m_last_day)
    );

    // Once a request is taken the block stays busy until its last day is loaded into the output register.
    a_busy_after_accept: assert property (
        @(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready
    ) else $error("s_ready high in the cycle after a request was accepted");

    // The divider only reports completion while the sequencer waits for it.
    a_div_done_expected: assert property (
        @(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_DIV_YEAR) || (state_reg == ST_DIV_SUM)
    ) else $error("divider completed outside a divide state");

    // No month is shorter than 28 days.
    a_last_day_range: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_day) |-> (m_day_of_month >= DAYS_FEB)
    ) else $error("last day marker on a day before the 28th");

    // Day transactions of a month start only when the sequencer moves on to emit them.
    a_emit_start_idle: assert property (
        @(posedge aclk) disable iff (!aresetn)
        emit_cmd.start |=> (state_reg == ST_EMIT)
    ) else $error("day emitter started without the sequencer following");

    // A weekday code never exceeds Saturday.
    a_weekday_range: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_weekday <= WD_SATURDAY)
    ) else $error("weekday out of range");

endmodule

`default_nettype wire

@@ design/mcl_div_unit.sv @@
// ----------------------------------------------------------------------------
// mcl_div_unit: shared divider by a selectable constant
// Holds the dividend, multiplies it by a scaled reciprocal for the quotient,
// then subtracts for the remainder. Used for the century split of the year
// and for the reduction modulo seven.
// ----------------------------------------------------------------------------
`default_nettype none

module mcl_div_unit
    import mcl_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int PROD_W = DIV_W + RECIP_W;

    logic             mul_pend_reg, mul_pend_next;
    logic             rem_pend_reg, rem_pend_next;
    logic             done_reg, done_next;
    div_sel_t         sel_reg, sel_next;
    logic [DIV_W-1:0] dvd_reg, dvd_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [REM_W-1:0] rem_reg, rem_next;

    logic [REM_W-1:0]   divisor;
    logic [RECIP_W-1:0] recip;
    logic [PROD_W-1:0]  product;
    logic [DIV_W-1:0]   quo_est;
    logic [DIV_W-1:0]   quo_times_div;

    always_comb begin
        case (sel_reg)
            DIV_BY_CENTURY: begin
                divisor = DIVISOR_CENTURY;
                recip   = RECIP_CENTURY;
            end
            DIV_BY_WEEK: begin
                divisor = DIVISOR_WEEK;
                recip   = RECIP_WEEK;
            end
            default: begin
                divisor = DIVISOR_WEEK;
                recip   = RECIP_WEEK;
            end
        endcase
    end

    assign product = {{RECIP_W{1'b0}}, dvd_reg} * {{DIV_W{1'b0}}, recip};

    always_comb begin
        case (sel_reg)
            DIV_BY_CENTURY: quo_est = DIV_W'(product >> RECIP_SHIFT_CENTURY);
            DIV_BY_WEEK:    quo_est = DIV_W'(product >> RECIP_SHIFT_WEEK);
            default:        quo_est = DIV_W'(product >> RECIP_SHIFT_WEEK);
        endcase
    end

    assign quo_times_div = quo_reg * {{(DIV_W-REM_W){1'b0}}, divisor};

    always_comb begin
        mul_pend_next = 1'b0;
        rem_pend_next = 1'b0;
        done_next     = 1'b0;
        sel_next      = sel_reg;
        dvd_next      = dvd_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        if (req.start) begin
            mul_pend_next = 1'b1;
            sel_next      = req.sel;
            dvd_next      = req.dividend;
        end
        if (mul_pend_reg) begin
            rem_pend_next = 1'b1;
            quo_next      = quo_est;
        end
        if (rem_pend_reg) begin
            done_next = 1'b1;
            rem_next  = REM_W'(dvd_reg - quo_times_div);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_pend_reg <= 1'b0;
            rem_pend_reg <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            mul_pend_reg <= mul_pend_next;
            rem_pend_reg <= rem_pend_next;
            done_reg     <= done_next;
        end
        sel_reg <= sel_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

@@ design/mcl_day_emitter.sv @@
// ----------------------------------------------------------------------------
// mcl_day_emitter: walks the days of the month into the output register
// Counts day and weekday together and presents one transaction per day.
// ----------------------------------------------------------------------------
`default_nettype none

module mcl_day_emitter
    import mcl_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire emit_cmd_t             cmd,
    output logic                       done,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [DAY_W-1:0]           m_day_of_month,
    output logic [WEEKDAY_W-1:0]       m_weekday,
    output logic                       m_is_weekend,
    output logic                       m_is_today,
    output logic                       m_last_day
);

    logic                 active_reg, active_next;
    logic [DAY_W-1:0]     day_reg, day_next;
    logic [WEEKDAY_W-1:0] wd_reg, wd_next;
    logic [DAY_W-1:0]     days_reg, days_next;
    logic                 match_reg, match_next;
    logic [DAY_W-1:0]     tday_reg, tday_next;

    logic                 out_valid_reg, out_valid_next;
    logic [DAY_W-1:0]     out_day_reg, out_day_next;
    logic [WEEKDAY_W-1:0] out_wd_reg, out_wd_next;
    logic                 out_weekend_reg, out_weekend_next;
    logic                 out_today_reg, out_today_next;
    logic                 out_last_reg, out_last_next;

    logic                 load_ok;
    logic                 step;
    logic                 is_last;

    assign load_ok = !out_valid_reg || m_ready;
    assign step    = active_reg && load_ok;
    assign is_last = (day_reg == days_reg);
    assign done    = step && is_last;

    always_comb begin
        active_next      = active_reg;
        day_next         = day_reg;
        wd_next          = wd_reg;
        days_next        = days_reg;
        match_next       = match_reg;
        tday_next        = tday_reg;
        out_valid_next   = out_valid_reg;
        out_day_next     = out_day_reg;
        out_wd_next      = out_wd_reg;
        out_weekend_next = out_weekend_reg;
        out_today_next   = out_today_reg;
        out_last_next    = out_last_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        if (cmd.start) begin
            active_next = 1'b1;
            day_next    = DAY_FIRST;
            wd_next     = cmd.first_wd;
            days_next   = cmd.days;
            match_next  = cmd.month_match;
            tday_next   = cmd.today_day;
        end else if (step) begin
            out_valid_next   = 1'b1;
            out_day_next     = day_reg;
            out_wd_next      = wd_reg;
            out_weekend_next = (wd_reg == WD_SUNDAY) || (wd_reg == WD_SATURDAY);
            out_today_next   = match_reg && (day_reg == tday_reg);
            out_last_next    = is_last;
            day_next         = day_reg + DAY_W'(1);
            wd_next          = (wd_reg == WD_SATURDAY) ? WD_SUNDAY : wd_reg + WEEKDAY_W'(1);
            if (is_last) begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
        day_reg         <= day_next;
        wd_reg          <= wd_next;
        days_reg        <= days_next;
        match_reg       <= match_next;
        tday_reg        <= tday_next;
        out_day_reg     <= out_day_next;
        out_wd_reg      <= out_wd_next;
        out_weekend_reg <= out_weekend_next;
        out_today_reg   <= out_today_next;
        out_last_reg    <= out_last_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_day_of_month = out_day_reg;
    assign m_weekday      = out_wd_reg;
    assign m_is_weekend   = out_weekend_reg;
    assign m_is_today     = out_today_reg;
    assign m_last_day     = out_last_reg;

endmodule

`default_nettype wire
